@@ rtl/kr_pkg.sv @@
// Shared types, codes and helpers for the keyed record table.
package kr_pkg;

  localparam int ENTRIES      = 16;
  localparam int NAME_BYTES   = 8;
  localparam int EXPIRY_BYTES = 8;
  localparam int IDX_W        = $clog2(ENTRIES);
  localparam int CNT_W        = $clog2(ENTRIES + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] count_t;
  typedef logic [2:0]       action_t;
  typedef logic [1:0]       status_t;

  // Request codes
  localparam action_t ACT_LOOKUP = 3'd0;
  localparam action_t ACT_ADD    = 3'd1;
  localparam action_t ACT_REMOVE = 3'd2;
  localparam action_t ACT_FIND   = 3'd3;
  localparam action_t ACT_CLEAR  = 3'd4;

  // Result codes
  localparam status_t STS_OK    = 2'd0;
  localparam status_t STS_MISS  = 2'd1;
  localparam status_t STS_FULL  = 2'd2;
  localparam status_t STS_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // One table slot as it travels around the ring
  typedef struct packed {
    logic        valid;
    logic [7:0]  key;
    logic [63:0] name;
    logic [63:0] expiry;
  } slot_t;

  // Ring control from the sequencer
  typedef struct packed {
    logic  shift;
    logic  load;
    logic  drop;
    logic  flush;
    idx_t  idx;
    slot_t data;
  } ring_ctl_t;

  // Cut a packed string at its first zero byte and keep at most nbytes bytes
  function automatic logic [63:0] cut_text(input logic [63:0] v, input int nbytes);
    logic [63:0] r;
    logic        stop;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i >= nbytes || v[8*i +: 8] == 8'h00) begin
        stop = 1'b1;
      end
      if (!stop) begin
        r[8*i +: 8] = v[8*i +: 8];
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/keyed_record_table.sv @@
// Top level of the keyed record table: ring of slot cells plus sequencer.
//
// Usage: drive action, key, name_text and expiry_text and raise start; the
// request transfers at a rising edge where start is high and busy is low.
// Actions: lookup, add or update, remove, find key by name, clear.
// The slots sit in a ring of ENTRIES cells that rotates by one cell per
// cycle while a request is scanned; the sequencer inspects the cell at
// the head, so one full turn brings every slot past it and back home.
// Steps: after the transfer the sequencer scans every slot at the head,
// then enters the commit cycle, in which done is high for exactly one
// cycle with status, key_out, name_out, expiry_out and live_count valid,
// and any slot write takes effect. Busy is high during the scan, so no
// new request transfers before the commit cycle; busy is low during the
// commit cycle, so the next request may transfer at its closing edge.
// The receiver cannot stall: each result is taken in its done cycle.
// Reset (rst, synchronous, active high) empties the table and zeroes the
// live count; no request in flight survives it.
module keyed_record_table (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [2:0]             action,
  input  logic [7:0]             key,
  input  logic [63:0]            name_text,
  input  logic [63:0]            expiry_text,
  output logic                   busy,
  output logic                   done,
  output logic [1:0]             status,
  output logic [7:0]             key_out,
  output logic [63:0]            name_out,
  output logic [63:0]            expiry_out,
  output logic [kr_pkg::CNT_W-1:0] live_count
);

  kr_pkg::slot_t     slots [kr_pkg::ENTRIES];
  kr_pkg::ring_ctl_t ring;

  kr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .action      (action),
    .key         (key),
    .name_text   (name_text),
    .expiry_text (expiry_text),
    .head        (slots[0]),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .key_out     (key_out),
    .name_out    (name_out),
    .expiry_out  (expiry_out),
    .live_count  (live_count),
    .ring        (ring)
  );

  // Ring of cells: each takes its upper neighbor, the last wraps to the head
  for (genvar i = 0; i < kr_pkg::ENTRIES; i++) begin : g_cell
    logic sel;
    assign sel = (ring.idx == kr_pkg::idx_t'(i));

    kr_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ring.shift),
      .load  (ring.load && sel),
      .drop  (ring.drop && sel),
      .flush (ring.flush),
      .nbr   (slots[(i + 1) % kr_pkg::ENTRIES]),
      .wdata (ring.data),
      .slot  (slots[i])
    );
  end

endmodule

@@ rtl/kr_cell.sv @@
// One slot register of the table ring.
module kr_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  logic          load,
  input  logic          drop,
  input  logic          flush,
  input  kr_pkg::slot_t nbr,
  input  kr_pkg::slot_t wdata,
  output kr_pkg::slot_t slot
);

  // Clear the valid mark under reset or flush; payload needs no reset
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      slot.valid <= 1'b0;
    end else if (load) begin
      slot.valid <= wdata.valid;
    end else if (drop) begin
      slot.valid <= 1'b0;
    end else if (shift) begin
      slot.valid <= nbr.valid;
    end
    // Take new contents on a write, else advance from the neighbor
    if (load) begin
      slot.key    <= wdata.key;
      slot.name   <= wdata.name;
      slot.expiry <= wdata.expiry;
    end else if (shift && !flush) begin
      slot.key    <= nbr.key;
      slot.name   <= nbr.name;
      slot.expiry <= nbr.expiry;
    end
  end

endmodule

@@ rtl/kr_ctrl.sv @@
// Request sequencer: scans the ring head, then commits the write and the result.
module kr_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  kr_pkg::action_t             action,
  input  logic [7:0]                  key,
  input  logic [63:0]                 name_text,
  input  logic [63:0]                 expiry_text,
  input  kr_pkg::slot_t               head,
  output logic                        busy,
  output logic                        done,
  output kr_pkg::status_t             status,
  output logic [7:0]                  key_out,
  output logic [63:0]                 name_out,
  output logic [63:0]                 expiry_out,
  output kr_pkg::count_t              live_count,
  output kr_pkg::ring_ctl_t           ring
);

  kr_pkg::state_t  state, state_next;
  kr_pkg::idx_t    cnt;
  kr_pkg::count_t  count, count_next;
  logic            last;
  logic            accept;

  // Latched request
  kr_pkg::action_t req_act;
  logic [7:0]      req_key;
  logic [63:0]     req_want;
  logic [63:0]     req_name;
  logic [63:0]     req_exp;

  // Scan findings
  logic            key_hit;
  kr_pkg::idx_t    key_idx;
  logic [63:0]     hit_name;
  logic [63:0]     hit_exp;
  logic            free_hit;
  kr_pkg::idx_t    free_idx;
  logic            name_hit;
  logic [7:0]      name_key;

  assign busy   = (state == kr_pkg::ST_SCAN);
  assign accept = start && !busy;
  assign last   = (cnt == kr_pkg::idx_t'(kr_pkg::ENTRIES - 1));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      kr_pkg::ST_IDLE: begin
        if (accept) state_next = kr_pkg::ST_SCAN;
      end
      kr_pkg::ST_SCAN: begin
        if (last) state_next = kr_pkg::ST_DONE;
      end
      kr_pkg::ST_DONE: begin
        state_next = accept ? kr_pkg::ST_SCAN : kr_pkg::ST_IDLE;
      end
      default: state_next = kr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kr_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Latch the request and pre-cut the texts
  always_ff @(posedge clk) begin
    if (accept) begin
      req_act  <= action;
      req_key  <= key;
      req_want <= kr_pkg::cut_text(name_text, 8);
      req_name <= kr_pkg::cut_text(name_text, kr_pkg::NAME_BYTES);
      req_exp  <= kr_pkg::cut_text(expiry_text, kr_pkg::EXPIRY_BYTES);
    end
  end

  // Advance the slot counter and record the first hits at the ring head
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      key_hit  <= 1'b0;
      free_hit <= 1'b0;
      name_hit <= 1'b0;
    end else if (accept) begin
      cnt      <= '0;
      key_hit  <= 1'b0;
      free_hit <= 1'b0;
      name_hit <= 1'b0;
    end else if (state == kr_pkg::ST_SCAN) begin
      cnt <= cnt + 1'b1;
      if (head.valid && head.key == req_key && !key_hit) begin
        key_hit  <= 1'b1;
        key_idx  <= cnt;
        hit_name <= head.name;
        hit_exp  <= head.expiry;
      end
      if (!head.valid && !free_hit) begin
        free_hit <= 1'b1;
        free_idx <= cnt;
      end
      if (head.valid && head.name == req_want && !name_hit) begin
        name_hit <= 1'b1;
        name_key <= head.key;
      end
    end
  end

  // Result and ring writes
  always_comb begin
    done        = 1'b0;
    status      = kr_pkg::STS_MISS;
    key_out     = req_key;
    name_out    = '0;
    expiry_out  = '0;
    count_next  = count;
    ring.shift  = (state == kr_pkg::ST_SCAN);
    ring.load   = 1'b0;
    ring.drop   = 1'b0;
    ring.flush  = 1'b0;
    ring.idx    = key_idx;
    ring.data.valid  = 1'b1;
    ring.data.key    = req_key;
    ring.data.name   = req_name;
    ring.data.expiry = req_exp;
    if (state == kr_pkg::ST_DONE) begin
      done = 1'b1;
      case (req_act)
        kr_pkg::ACT_LOOKUP: begin
          if (key_hit) begin
            status     = kr_pkg::STS_OK;
            name_out   = hit_name;
            expiry_out = hit_exp;
          end
        end
        kr_pkg::ACT_ADD: begin
          if (req_want[7:0] == 8'h00) begin
            status = kr_pkg::STS_EMPTY;
          end else if (key_hit) begin
            status    = kr_pkg::STS_OK;
            ring.load = 1'b1;
          end else if (free_hit) begin
            status     = kr_pkg::STS_OK;
            ring.load  = 1'b1;
            ring.idx   = free_idx;
            count_next = count + 1'b1;
          end else begin
            status = kr_pkg::STS_FULL;
          end
        end
        kr_pkg::ACT_REMOVE: begin
          if (key_hit) begin
            status     = kr_pkg::STS_OK;
            ring.drop  = 1'b1;
            count_next = count - 1'b1;
          end
        end
        kr_pkg::ACT_FIND: begin
          if (name_hit && req_want != 64'd0) begin
            status  = kr_pkg::STS_OK;
            key_out = name_key;
          end
        end
        kr_pkg::ACT_CLEAR: begin
          status     = kr_pkg::STS_OK;
          ring.flush = 1'b1;
          count_next = '0;
        end
        default: status = kr_pkg::STS_MISS;
      endcase
    end
  end

  assign live_count = count_next;

  // Scan always lasts exactly one pass around the ring
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == kr_pkg::ST_SCAN && last) |=> state == kr_pkg::ST_DONE)
    else $error("scan did not end after one pass");

  // Accepted request starts a fresh pass at slot zero
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == kr_pkg::ST_SCAN && cnt == '0))
    else $error("scan did not start at slot zero");

  // Live count never exceeds the table size
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= kr_pkg::count_t'(kr_pkg::ENTRIES))
    else $error("live count overflow");

  // Ring writes happen only in the commit cycle, and never during a shift
  a_write_done: assert property (@(posedge clk) disable iff (rst)
    (ring.load || ring.drop || ring.flush) |-> (done && !ring.shift))
    else $error("ring write outside commit");

  // Clear leaves an empty table
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (done && req_act == kr_pkg::ACT_CLEAR) |=> count == '0)
    else $error("clear left entries counted");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the keyed record table: directed and random requests.
module tb;
  import kr_pkg::*;

  localparam int STALL_LIMIT = 500;
  localparam int KEY_POOL    = 24;
  localparam int NAME_POOL   = 8;

  // One reply as the block presents it
  typedef struct packed {
    status_t     status;
    logic [7:0]  key_out;
    logic [63:0] name_out;
    logic [63:0] expiry_out;
    count_t      live_count;
  } table_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  action_t     action = ACT_LOOKUP;
  logic [7:0]  key = '0;
  logic [63:0] name_text = '0;
  logic [63:0] expiry_text = '0;
  logic        busy;
  logic        done;
  status_t     status;
  logic [7:0]  key_out;
  logic [63:0] name_out;
  logic [63:0] expiry_out;
  count_t      live_count;

  // Shadow copy of the table
  bit          shadow_valid [ENTRIES];
  bit [7:0]    shadow_key [ENTRIES];
  bit [63:0]   shadow_name [ENTRIES];
  bit [63:0]   shadow_expiry [ENTRIES];
  int          shadow_count;

  table_reply_t pending_replies[$];
  int           error_count = 0;
  int           idle_cycles = 0;
  bit           steady = 1'b0;
  logic [7:0]   key_pool [KEY_POOL];
  logic [63:0]  name_pool [NAME_POOL];

  keyed_record_table uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .action      (action),
    .key         (key),
    .name_text   (name_text),
    .expiry_text (expiry_text),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .key_out     (key_out),
    .name_out    (name_out),
    .expiry_out  (expiry_out),
    .live_count  (live_count)
  );

  always #5 clk = ~clk;

  // Keep bytes up to the first zero byte, at most keep bytes
  function automatic logic [63:0] trim_text(input logic [63:0] raw, input int keep);
    logic [63:0] t;
    int          n;
    t = '0;
    n = 0;
    while (n < keep && n < 8 && raw[8*n +: 8] != 8'h00) begin
      t[8*n +: 8] = raw[8*n +: 8];
      n++;
    end
    return t;
  endfunction

  // Random text of min_len to 8 bytes, with junk after the terminator
  function automatic logic [63:0] rand_text(input int min_len);
    logic [63:0] t;
    int          len;
    t   = {$urandom, $urandom};
    len = $urandom_range(min_len, 8);
    for (int i = 0; i < 8; i++) begin
      if (i < len) begin
        t[8*i +: 8] = 8'($urandom_range(1, 255));
      end else if (i == len) begin
        t[8*i +: 8] = 8'h00;
      end
    end
    return t;
  endfunction

  // Apply one request to the shadow table and return the reply it gives
  function automatic table_reply_t apply_request(input action_t op, input logic [7:0] k,
                                                 input logic [63:0] nm,
                                                 input logic [63:0] ex);
    table_reply_t r;
    int          hit;
    int          slot;
    logic [63:0] want;
    bit          found;
    r.status     = STS_OK;
    r.key_out    = k;
    r.name_out   = '0;
    r.expiry_out = '0;
    hit = -1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (shadow_valid[i] && shadow_key[i] == k) hit = i;
    end
    case (op)
      ACT_LOOKUP: begin
        if (hit < 0) begin
          r.status = STS_MISS;
        end else begin
          r.name_out   = shadow_name[hit];
          r.expiry_out = shadow_expiry[hit];
        end
      end
      ACT_ADD: begin
        if (nm[7:0] == 8'h00) begin
          r.status = STS_EMPTY;
        end else begin
          slot = hit;
          if (slot < 0) begin
            for (int i = ENTRIES - 1; i >= 0; i--) begin
              if (!shadow_valid[i]) slot = i;
            end
          end
          if (slot < 0) begin
            r.status = STS_FULL;
          end else begin
            if (hit < 0) shadow_count++;
            shadow_valid[slot]  = 1'b1;
            shadow_key[slot]    = k;
            shadow_name[slot]   = trim_text(nm, NAME_BYTES);
            shadow_expiry[slot] = trim_text(ex, EXPIRY_BYTES);
          end
        end
      end
      ACT_REMOVE: begin
        if (hit < 0) begin
          r.status = STS_MISS;
        end else begin
          shadow_valid[hit] = 1'b0;
          shadow_count--;
        end
      end
      ACT_FIND: begin
        want     = trim_text(nm, 8);
        found    = 1'b0;
        r.status = STS_MISS;
        if (want != '0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (!found && shadow_valid[i] && shadow_name[i] == want) begin
              found     = 1'b1;
              r.status  = STS_OK;
              r.key_out = shadow_key[i];
            end
          end
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) begin
          shadow_valid[i]  = 1'b0;
          shadow_key[i]    = '0;
          shadow_name[i]   = '0;
          shadow_expiry[i] = '0;
        end
        shadow_count = 0;
      end
      default: r.status = STS_MISS;
    endcase
    r.live_count = count_t'(shadow_count);
    return r;
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  // Send one request, idling first at random, and queue its reply
  task automatic send_request(input action_t op, input logic [7:0] k,
                              input logic [63:0] nm, input logic [63:0] ex);
    int gap;
    gap = 0;
    // idle about one ready cycle in six, except in steady stretches
    while (!steady && $urandom_range(99) < 16) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      // let the pass in flight finish so each gap cycle is a ready cycle
      do @(posedge clk); while (busy);
      repeat (gap - 1) @(posedge clk);
    end
    start       <= 1'b1;
    action      <= op;
    key         <= k;
    name_text   <= nm;
    expiry_text <= ex;
    // hold until the transfer edge
    do @(posedge clk); while (busy);
    pending_replies.push_back(apply_request(op, k, nm, ex));
  endtask

  // Compare each reply with the oldest one pending
  always @(posedge clk) begin : check_replies
    table_reply_t want;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with no request pending");
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (key_out !== want.key_out)
          report_mismatch($sformatf("key_out %h, want %h", key_out, want.key_out));
        if (name_out !== want.name_out)
          report_mismatch($sformatf("name_out %h, want %h", name_out, want.name_out));
        if (expiry_out !== want.expiry_out)
          report_mismatch($sformatf("expiry_out %h, want %h", expiry_out, want.expiry_out));
        if (live_count !== want.live_count)
          report_mismatch($sformatf("live_count %0d, want %0d", live_count,
                                    want.live_count));
      end
    end
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if ((start && !busy && !rst) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Misses, empty names, truncation, name search order, unused codes, clear
  task automatic test_special_cases();
    send_request(ACT_LOOKUP, 8'h00, '0, '0);
    send_request(ACT_REMOVE, 8'hFF, '1, '1);
    send_request(ACT_FIND, 8'hA5, '0, '1);
    send_request(ACT_ADD, 8'h5A, 64'hFFFF_FFFF_FFFF_FF00, '1);
    send_request(ACT_ADD, 8'h00, '1, '1);
    send_request(ACT_ADD, 8'hFF, 64'hFFFF_FFFF_0000_4241, 64'hFFFF_FFFF_FFFF_FF00);
    send_request(ACT_LOOKUP, 8'h00, '0, '0);
    send_request(ACT_LOOKUP, 8'hFF, '1, '1);
    send_request(ACT_FIND, 8'h11, 64'h0000_0000_0000_4241, '0);
    send_request(ACT_FIND, 8'h22, 64'h0011_2233_0000_4241, '0);
    send_request(ACT_ADD, 8'h00, 64'h0000_0000_0000_4241, 64'hA5A5_0000_0039_3132);
    send_request(ACT_FIND, 8'h33, 64'h0000_0000_0000_4241, '0);
    send_request(ACT_REMOVE, 8'h00, '0, '0);
    send_request(ACT_LOOKUP, 8'h00, '0, '0);
    send_request(ACT_FIND, 8'h44, 64'h0000_0000_0000_4241, '0);
    send_request(action_t'('1), 8'h00, '1, '1);
    send_request(action_t'(ACT_CLEAR + 1), 8'hFF, '1, '1);
    send_request(ACT_CLEAR, 8'h77, '1, '1);
    send_request(ACT_LOOKUP, 8'hFF, '0, '0);
    send_request(ACT_REMOVE, 8'hFF, '0, '0);
  endtask

  // Mixed requests over a small set of keys and names
  task automatic test_random_mix(input int count);
    int          pick;
    action_t     op;
    logic [63:0] nm;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      nm   = name_pool[$urandom_range(NAME_POOL - 1)];
      if (pick < 38) begin
        op = ACT_ADD;
        if ($urandom_range(99) < 15) nm = rand_text(0);
      end else if (pick < 58) begin
        op = ACT_LOOKUP;
      end else if (pick < 73) begin
        op = ACT_FIND;
        if ($urandom_range(99) < 30) nm = rand_text(0);
      end else if (pick < 89) begin
        op = ACT_REMOVE;
      end else if (pick < 93) begin
        op = ACT_CLEAR;
      end else begin
        op = action_t'($urandom_range(int'(ACT_CLEAR) + 1, (1 << $bits(action_t)) - 1));
      end
      send_request(op, key_pool[$urandom_range(KEY_POOL - 1)], nm, rand_text(0));
    end
  endtask

  // Add-heavy traffic that fills the table, sent back to back
  task automatic test_random_fill(input int count);
    int      pick;
    action_t op;
    steady = 1'b1;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 70) op = ACT_ADD;
      else if (pick < 80) op = ACT_REMOVE;
      else if (pick < 90) op = ACT_LOOKUP;
      else op = ACT_FIND;
      send_request(op, key_pool[$urandom_range(KEY_POOL - 1)],
                   name_pool[$urandom_range(NAME_POOL - 1)], rand_text(0));
    end
    steady = 1'b0;
  endtask

  // Fully random fields and codes
  task automatic test_random_noise(input int count);
    for (int n = 0; n < count; n++) begin
      send_request(action_t'($urandom), 8'($urandom), {$urandom, $urandom},
                   {$urandom, $urandom});
    end
  endtask

  initial begin
    // build the key and name sets, with both key extremes
    key_pool[0] = 8'h00;
    key_pool[1] = 8'hFF;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = 8'($urandom);
    for (int i = 0; i < NAME_POOL; i++) name_pool[i] = rand_text(1);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_special_cases();
    test_random_mix(160);
    test_random_fill(120);
    test_random_noise(120);
    start <= 1'b0;

    // drain the remaining replies, then watch for strays
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (ENTRIES + 4) @(posedge clk);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/kr_pkg.sv
rtl/kr_cell.sv
rtl/kr_ctrl.sv
rtl/keyed_record_table.sv
test/tb.sv
